// ----- hdl/ssp_pkg.sv -----
// Shared constants, register map and widths for the sprite screen projection.
// No dependencies; used by ssp_div and sprite_screen_projection.
package ssp_pkg;

  localparam int POS_FRAC_BITS = 10;
  localparam int VEC_FRAC_BITS = 14;
  localparam int MAX_SCREEN    = 2048;

  localparam int DEPTH_SHIFT = VEC_FRAC_BITS + 8 - POS_FRAC_BITS;
  localparam int VSHIFT_NUM  = 25600;
  localparam int SIZE_SHIFT  = 8;
  localparam int SIZE_MAX    = 4095;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int NUM_W = 46;
  localparam int DEN_W = 34;
  localparam int QUO_W = 15;
  localparam int CMP_W = DEN_W + QUO_W;

  typedef enum logic [2:0] {
    REG_PLAYER_X,
    REG_PLAYER_Y,
    REG_VIEW_DIR_X,
    REG_VIEW_DIR_Y,
    REG_CAM_PLANE_X,
    REG_CAM_PLANE_Y,
    REG_SCREEN_W,
    REG_SCREEN_H
  } reg_idx_t;

  localparam logic [15:0] RST_PLAYER_X    = 16'h0000;
  localparam logic [15:0] RST_PLAYER_Y    = 16'h0000;
  localparam logic [15:0] RST_VIEW_DIR_X  = 16'hC000;
  localparam logic [15:0] RST_VIEW_DIR_Y  = 16'h0000;
  localparam logic [15:0] RST_CAM_PLANE_X = 16'h0000;
  localparam logic [15:0] RST_CAM_PLANE_Y = 16'd10813;
  localparam logic [11:0] RST_SCREEN_W    = 12'd640;
  localparam logic [11:0] RST_SCREEN_H    = 12'd480;

endpackage

// ----- hdl/sprite_screen_projection.sv -----
// Sprite screen projection: camera transform, depth, center column and clipped rectangle.
// Depends on ssp_pkg and ssp_div.
//
// Usage: pulse start with sprite_x/sprite_y; busy is always low, so a request
// is taken in every cycle start is high. Each request yields one result on the
// output ports, marked by done for exactly one cycle. Throughput is one request
// per cycle: the four dividers are pipelines of an input register and 15
// stages, one quotient bit per stage, and the depth divide feeds the size and
// vertical shift divides, which sets the latency.
// Camera and screen registers sit on an APB-style port (pready always high),
// register i at byte address 4*i; write them only while no request is in
// flight. Reset restores the default camera and clears all in-flight requests.
// The receiver cannot stall; results are never held.
module sprite_screen_projection (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [15:0]                 sprite_x,
  input  logic [15:0]                 sprite_y,
  output logic                        done,
  output logic                        in_front,
  output logic signed [15:0]          depth,
  output logic signed [12:0]          center_column,
  output logic [11:0]                 sprite_size,
  output logic [11:0]                 start_col,
  output logic signed [12:0]          end_col,
  output logic [11:0]                 start_row,
  output logic signed [12:0]          end_row,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssp_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssp_pkg::DATA_W-1:0]  pwdata,
  output logic [ssp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ssp_pkg::*;

  localparam int VLD_LEN = 37;
  localparam int LINE_A  = 16;
  localparam int LINE_B  = 16;
  localparam int LINE_D  = 16;
  localparam int LINE_C  = 15;

  logic [15:0] player_x, player_y;
  logic signed [15:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;
  logic [11:0] screen_w, screen_h;
  logic [11:0] w_eff, h_eff;
  reg_idx_t    ridx;
  logic        wr_en;

  assign ridx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x    <= RST_PLAYER_X;
      player_y    <= RST_PLAYER_Y;
      view_dir_x  <= RST_VIEW_DIR_X;
      view_dir_y  <= RST_VIEW_DIR_Y;
      cam_plane_x <= RST_CAM_PLANE_X;
      cam_plane_y <= RST_CAM_PLANE_Y;
      screen_w    <= RST_SCREEN_W;
      screen_h    <= RST_SCREEN_H;
    end else if (wr_en) begin
      unique case (ridx)
        REG_PLAYER_X:    player_x    <= pwdata[15:0];
        REG_PLAYER_Y:    player_y    <= pwdata[15:0];
        REG_VIEW_DIR_X:  view_dir_x  <= pwdata[15:0];
        REG_VIEW_DIR_Y:  view_dir_y  <= pwdata[15:0];
        REG_CAM_PLANE_X: cam_plane_x <= pwdata[15:0];
        REG_CAM_PLANE_Y: cam_plane_y <= pwdata[15:0];
        REG_SCREEN_W:    screen_w    <= pwdata[11:0];
        REG_SCREEN_H:    screen_h    <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_PLAYER_X:    prdata = DATA_W'(player_x);
      REG_PLAYER_Y:    prdata = DATA_W'(player_y);
      REG_VIEW_DIR_X:  prdata = DATA_W'(unsigned'(view_dir_x));
      REG_VIEW_DIR_Y:  prdata = DATA_W'(unsigned'(view_dir_y));
      REG_CAM_PLANE_X: prdata = DATA_W'(unsigned'(cam_plane_x));
      REG_CAM_PLANE_Y: prdata = DATA_W'(unsigned'(cam_plane_y));
      REG_SCREEN_W:    prdata = DATA_W'(screen_w);
      REG_SCREEN_H:    prdata = DATA_W'(screen_h);
    endcase
  end

  assign w_eff = (screen_w > 12'(MAX_SCREEN)) ? 12'(MAX_SCREEN) : screen_w;
  assign h_eff = (screen_h > 12'(MAX_SCREEN)) ? 12'(MAX_SCREEN) : screen_h;

  // camera determinant, registered from the settings
  logic signed [32:0] det, det_next;
  assign det_next = cam_plane_x * view_dir_y - view_dir_x * cam_plane_y;
  always_ff @(posedge clk) det <= det_next;

  logic [VLD_LEN-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[VLD_LEN-2:0], start};
      done <= vld[VLD_LEN-1];
    end
  end

  // relative position, products, camera-space coordinates
  logic signed [16:0] rx, ry;
  logic signed [32:0] p_dy_rx, p_dx_ry, p_px_ry, p_py_rx;
  logic signed [33:0] tx, ty;
  always_ff @(posedge clk) begin
    rx      <= signed'({1'b0, sprite_x}) - signed'({1'b0, player_x});
    ry      <= signed'({1'b0, sprite_y}) - signed'({1'b0, player_y});
    p_dy_rx <= view_dir_y * rx;
    p_dx_ry <= view_dir_x * ry;
    p_px_ry <= cam_plane_x * ry;
    p_py_rx <= cam_plane_y * rx;
    tx      <= 34'(p_dy_rx) - 34'(p_dx_ry);
    ty      <= 34'(p_px_ry) - 34'(p_py_rx);
  end

  logic [33:0] ty_abs;
  logic [32:0] det_abs;
  logic [NUM_W-1:0] num_a;
  logic [DEN_W-1:0] den_a;
  logic [QUO_W-1:0] q_a;
  assign ty_abs  = ty[33] ? 34'(-ty) : 34'(ty);
  assign det_abs = det[32] ? 33'(-det) : 33'(det);
  assign num_a   = NUM_W'(ty_abs) << DEPTH_SHIFT;
  assign den_a   = DEN_W'(det_abs);

  ssp_div u_div_depth (.clk(clk), .num(num_a), .den(den_a), .quo(q_a));

  logic [1:0] flag_a [0:LINE_A-1];
  logic signed [34:0] sum_tt;
  logic signed [33:0] ty_s4, ty_b;
  logic signed [45:0] cm;
  always_ff @(posedge clk) begin
    flag_a[0] <= {ty[33] ^ det[32], det != '0};
    for (int j = 1; j < LINE_A; j++) flag_a[j] <= flag_a[j-1];
    sum_tt <= 35'(ty) + 35'(tx);
    ty_s4  <= ty;
    cm     <= sum_tt * signed'(46'(w_eff >> 1));
    ty_b   <= ty_s4;
  end

  logic [NUM_W-1:0] num_b;
  logic [DEN_W-1:0] den_b;
  logic [QUO_W-1:0] q_b;
  assign num_b = cm[45] ? NUM_W'(-cm) : NUM_W'(cm);
  assign den_b = ty_b[33] ? DEN_W'(-ty_b) : DEN_W'(ty_b);

  ssp_div u_div_center (.clk(clk), .num(num_b), .den(den_b), .quo(q_b));

  logic neg_b [0:LINE_B-1];
  always_ff @(posedge clk) begin
    neg_b[0] <= cm[45] ^ ty_b[33];
    for (int j = 1; j < LINE_B; j++) neg_b[j] <= neg_b[j-1];
  end

  // depth with front test
  logic [QUO_W-1:0] depth_q;
  logic             front_q;
  always_ff @(posedge clk) begin
    depth_q <= q_a;
    front_q <= !flag_a[LINE_A-1][1] && flag_a[LINE_A-1][0] && (q_a != '0);
  end

  logic [QUO_W-1:0] q_c, q_d;
  ssp_div u_div_vshift (.clk(clk), .num(NUM_W'(VSHIFT_NUM)), .den(DEN_W'(depth_q)),
                        .quo(q_c));
  ssp_div u_div_size (.clk(clk), .num(NUM_W'(h_eff) << SIZE_SHIFT),
                      .den(DEN_W'(depth_q)), .quo(q_d));

  logic [QUO_W:0] dline [0:LINE_D-1];
  logic signed [12:0] cen_next;
  logic signed [12:0] cline [0:LINE_C-1];

  always_comb begin
    if (neg_b[LINE_B-1])
      cen_next = (q_b >= QUO_W'(4096)) ? 13'sh1000 : -signed'(13'(q_b));
    else
      cen_next = (q_b >= QUO_W'(4095)) ? 13'sd4095 : signed'(13'(q_b));
  end

  always_ff @(posedge clk) begin
    dline[0] <= {front_q, depth_q};
    for (int j = 1; j < LINE_D; j++) dline[j] <= dline[j-1];
    cline[0] <= cen_next;
    for (int j = 1; j < LINE_C; j++) cline[j] <= cline[j-1];
  end

  // rectangle edges
  logic [11:0] size_next, size_r;
  logic [10:0] half;
  logic [15:0] base_r;
  logic signed [16:0] r_lo, r_hi;
  logic signed [13:0] c_lo, c_hi;
  logic signed [12:0] cen_r;
  logic [QUO_W-1:0] depth_r;
  logic front_r;

  assign size_next = (q_d >= QUO_W'(SIZE_MAX)) ? 12'(SIZE_MAX) : q_d[11:0];
  assign half      = size_next[11:1];
  assign base_r    = 16'(h_eff >> 1) + 16'(q_c);

  always_ff @(posedge clk) begin
    size_r  <= size_next;
    r_lo    <= signed'({1'b0, base_r}) - signed'(17'(half));
    r_hi    <= signed'({1'b0, base_r}) + signed'(17'(half));
    c_lo    <= 14'(cline[LINE_C-1]) - signed'(14'(half));
    c_hi    <= 14'(cline[LINE_C-1]) + signed'(14'(half));
    cen_r   <= cline[LINE_C-1];
    depth_r <= dline[LINE_D-1][QUO_W-1:0];
    front_r <= dline[LINE_D-1][QUO_W];
  end

  always_ff @(posedge clk) begin
    if (!front_r) begin
      in_front      <= 1'b0;
      depth         <= '0;
      center_column <= '0;
      sprite_size   <= '0;
      start_col     <= '0;
      end_col       <= '0;
      start_row     <= '0;
      end_row       <= '0;
    end else begin
      in_front      <= 1'b1;
      depth         <= signed'({1'b0, depth_r});
      center_column <= cen_r;
      sprite_size   <= size_r;
      start_row     <= r_lo[16] ? 12'd0 : (r_lo > 17'sd4095 ? 12'd4095 : r_lo[11:0]);
      end_row       <= (r_hi >= signed'(17'(h_eff))) ? signed'(13'(h_eff) - 13'd1)
                                                     : r_hi[12:0];
      start_col     <= c_lo[13] ? 12'd0 : (c_lo > 14'sd4095 ? 12'd4095 : c_lo[11:0]);
      end_col       <= (c_hi >= signed'(14'(w_eff))) ? signed'(13'(w_eff) - 13'd1)
                                                     : c_hi[12:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(start, VLD_LEN + 1))
    else $error("result without matching request");

  assert property (@(posedge clk) disable iff (rst)
    done && in_front |-> (depth != '0) && !depth[15])
    else $error("in-front result with non-positive depth");

  assert property (@(posedge clk) disable iff (rst)
    done && !in_front |-> (depth == '0) && (sprite_size == '0) && (end_row == '0))
    else $error("behind-camera result not cleared");

endmodule

// ----- hdl/ssp_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on ssp_pkg; quotient saturates to all ones when it would overflow.
module ssp_div (
  input  logic                       clk,
  input  logic [ssp_pkg::NUM_W-1:0]  num,
  input  logic [ssp_pkg::DEN_W-1:0]  den,
  output logic [ssp_pkg::QUO_W-1:0]  quo
);
  import ssp_pkg::*;

  logic [NUM_W-1:0] rem [0:QUO_W];
  logic [DEN_W-1:0] dv  [0:QUO_W];
  logic [QUO_W-1:0] qt  [0:QUO_W];
  logic             sat [0:QUO_W];

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= den;
    qt[0]  <= '0;
    sat[0] <= CMP_W'(num) >= {den, QUO_W'(0)};
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int SH = QUO_W - 1 - i;
    logic [CMP_W-1:0] trial;
    logic             take;
    assign trial = CMP_W'(dv[i]) << SH;
    assign take  = CMP_W'(rem[i]) >= trial;
    always_ff @(posedge clk) begin
      rem[i+1] <= take ? rem[i] - trial[NUM_W-1:0] : rem[i];
      dv[i+1]  <= dv[i];
      qt[i+1]  <= qt[i] | (QUO_W'(take) << SH);
      sat[i+1] <= sat[i];
    end
  end

  assign quo = sat[QUO_W] ? '1 : qt[QUO_W];

endmodule
